[hw/rtl/mwc_pkg.sv]
// Package with shared constants and types for the water cell step pipeline.
package mwc_pkg;

    // Fixed point format.
    localparam int FRAC_BITS = 16;

    // Field widths.
    localparam int WATER_W = 32;
    localparam int FLUX_W  = 31;
    localparam int TOT_W   = 33;
    localparam int TS_W    = 17;
    localparam int GAIN_W  = 20;
    localparam int STEP_W  = 16;

    // Width of the scaled total and of the divider remainder.
    localparam int PW = TOT_W + TS_W - FRAC_BITS;
    localparam int DW = (PW > WATER_W) ? PW : WATER_W;

    // Cycles from an accepted command to its result strobe.
    localparam int LATENCY = 6 + FRAC_BITS + 1;

    localparam logic [FLUX_W-1:0] FLUX_MAX = {FLUX_W{1'b1}};

    // Operation codes.
    typedef enum logic [1:0] {
        OP_RAIN  = 2'd0,
        OP_EVAP  = 2'd1,
        OP_FLUX  = 2'd2,
        OP_WATER = 2'd3
    } op_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_RAIN  = 3'd0;
    localparam logic [2:0] CFG_EVAP  = 3'd1;
    localparam logic [2:0] CFG_GAIN  = 3'd2;
    localparam logic [2:0] CFG_TSTEP = 3'd3;
    localparam logic [2:0] CFG_FLOOR = 3'd4;

    // Payload carried through the scaling divider.
    typedef struct packed {
        logic [WATER_W-1:0]        nw;
        logic [3:0][FLUX_W-1:0]    f;
        logic                      scale;
        logic [DW-1:0]             p;
        logic [DW-1:0]             rem;
        logic [FRAC_BITS-1:0]      q;
    } div_t;

endpackage

[hw/rtl/pipe_model_water_cell_step.sv]
// Top level of the pipelined virtual-pipe water cell update.
//
// Usage: a command (one cell) is accepted at a rising edge where start is
// high and busy is low. busy never rises, so one cell may enter every cycle.
// Each cell yields one result, shown on new_water and new_flux_* for exactly
// one cycle while done is high. Results come in command order.
// The flux scaling divider resolves one quotient bit per stage; six stages
// before it form the surface differences, gain products, clamps, the flux
// total and its time-step product, and one stage after it applies the
// scale factor. Throughput is one cell per cycle.
// The receiver cannot hold results off, and none is needed: each result is
// taken in the cycle it is shown.
// Configuration writes come through a valid/ready channel that is always
// ready; a transaction writes register cfg_index with cfg_data. Writes are to
// be made only while no command is in flight; the block does not enforce it.
// Reset empties the pipeline and loads the default register values.
module pipe_model_water_cell_step
    import mwc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                op,
    input  logic [3:0]                neighbor_valid,
    input  logic signed [31:0]        own_height,
    input  logic signed [31:0]        own_water,
    input  logic signed [31:0]        neighbor_east,
    input  logic signed [31:0]        neighbor_north,
    input  logic signed [31:0]        neighbor_west,
    input  logic signed [31:0]        neighbor_south,
    input  logic [30:0]               flux_east,
    input  logic [30:0]               flux_north,
    input  logic [30:0]               flux_west,
    input  logic [30:0]               flux_south,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [2:0]                cfg_index,
    input  logic [31:0]               cfg_data,
    output logic                      done,
    output logic signed [31:0]        new_water,
    output logic [30:0]               new_flux_east,
    output logic [30:0]               new_flux_north,
    output logic [30:0]               new_flux_west,
    output logic [30:0]               new_flux_south
);

    // Configuration registers.
    logic [STEP_W-1:0] rain_reg;
    logic [STEP_W-1:0] evap_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [TS_W-1:0]   ts_reg;
    logic [STEP_W-1:0] floor_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rain_reg  <= STEP_W'(66);
            evap_reg  <= STEP_W'(7);
            gain_reg  <= GAIN_W'(64225);
            ts_reg    <= TS_W'(6554);
            floor_reg <= STEP_W'(655);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RAIN:  rain_reg  <= cfg_data[STEP_W-1:0];
                CFG_EVAP:  evap_reg  <= cfg_data[STEP_W-1:0];
                CFG_GAIN:  gain_reg  <= cfg_data[GAIN_W-1:0];
                CFG_TSTEP: ts_reg    <= cfg_data[TS_W-1:0];
                CFG_FLOOR: floor_reg <= cfg_data[STEP_W-1:0];
                default:   ;
            endcase
        end
    end

    // Valid bits of the pipeline stages.
    logic       v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, vo_reg;
    logic [FRAC_BITS:0] vd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            vd_reg <= '0;
            vo_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            vd_reg <= {vd_reg[FRAC_BITS-1:0], v5_reg};
            vo_reg <= vd_reg[FRAC_BITS];
        end
    end

    // Stage 1: surface differences, inflow balance, rain and evaporation.
    logic signed [31:0]      nb_in [4];
    logic [FLUX_W-1:0]       fl_in [4];
    logic signed [32:0]      surf;
    logic signed [33:0]      d_next [4];
    logic signed [34:0]      diff_next;
    logic signed [32:0]      rain_sum;
    logic signed [32:0]      evap_sum;
    logic [WATER_W-1:0]      nw1_next;

    assign nb_in[0] = neighbor_east;
    assign nb_in[1] = neighbor_north;
    assign nb_in[2] = neighbor_west;
    assign nb_in[3] = neighbor_south;
    assign fl_in[0] = flux_east;
    assign fl_in[1] = flux_north;
    assign fl_in[2] = flux_west;
    assign fl_in[3] = flux_south;

    always_comb
    begin
        surf = {own_height[31], own_height} + {own_water[31], own_water};
        diff_next = '0;
        for (int i = 0; i < 4; i++)
        begin
            d_next[i] = {surf[32], surf} - {{2{nb_in[i][31]}}, nb_in[i]};
            if (neighbor_valid[i])
            begin
                diff_next = diff_next + {{3{nb_in[i][31]}}, nb_in[i]}
                            - $signed({4'b0, fl_in[i]});
            end
        end
        rain_sum = {own_water[31], own_water} + $signed({17'b0, rain_reg});
        evap_sum = {own_water[31], own_water} - $signed({17'b0, evap_reg});
        case (op_t'(op))
            OP_RAIN:
            begin
                if (rain_sum[32] != rain_sum[31])
                    nw1_next = {1'b0, {(WATER_W-1){1'b1}}};
                else
                    nw1_next = rain_sum[31:0];
            end
            OP_EVAP:  nw1_next = evap_sum[32] ? '0 : evap_sum[31:0];
            default:  nw1_next = own_water;
        endcase
    end

    logic [1:0]              op1_reg;
    logic [3:0]              nv1_reg;
    logic signed [31:0]      w1_reg;
    logic [WATER_W-1:0]      nw1_reg;
    logic signed [33:0]      d1_reg [4];
    logic signed [34:0]      diff1_reg;
    logic [FLUX_W-1:0]       fl1_reg [4];

    always_ff @(posedge clk)
    begin
        op1_reg   <= op;
        nv1_reg   <= neighbor_valid;
        w1_reg    <= own_water;
        nw1_reg   <= nw1_next;
        d1_reg    <= d_next;
        diff1_reg <= diff_next;
        fl1_reg   <= fl_in;
    end

    // Stage 2: gain products and the time-step product of the balance.
    logic [1:0]              op2_reg;
    logic [3:0]              nv2_reg;
    logic signed [31:0]      w2_reg;
    logic [WATER_W-1:0]      nw2_reg;
    logic signed [54:0]      prod2_reg [4];
    logic signed [52:0]      wprod2_reg;
    logic [FLUX_W-1:0]       fl2_reg [4];

    always_ff @(posedge clk)
    begin
        op2_reg <= op1_reg;
        nv2_reg <= nv1_reg;
        w2_reg  <= w1_reg;
        nw2_reg <= nw1_reg;
        fl2_reg <= fl1_reg;
        for (int i = 0; i < 4; i++)
            prod2_reg[i] <= d1_reg[i] * $signed({1'b0, gain_reg});
        wprod2_reg <= diff1_reg * $signed({1'b0, ts_reg});
    end

    // Stage 3: flux clamps and the saturated water update.
    logic signed [54:0]      fsum [4];
    logic [FLUX_W-1:0]       f3_next [4];
    logic signed [52:0]      wsum;
    logic [WATER_W-1:0]      nw3_next;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            fsum[i] = $signed({24'b0, fl2_reg[i]}) + (prod2_reg[i] >>> FRAC_BITS);
            if (op_t'(op2_reg) != OP_FLUX)
                f3_next[i] = fl2_reg[i];
            else if (!nv2_reg[i] || fsum[i] < 0)
                f3_next[i] = '0;
            else if (fsum[i] > $signed({24'b0, FLUX_MAX}))
                f3_next[i] = FLUX_MAX;
            else
                f3_next[i] = fsum[i][FLUX_W-1:0];
        end
        // The product keeps its sign through the shift, so the sum is signed.
        wsum = $signed({{21{w2_reg[31]}}, w2_reg}) + (wprod2_reg >>> FRAC_BITS);
        if (op_t'(op2_reg) != OP_WATER)
            nw3_next = nw2_reg;
        else if (wsum > $signed({21'b0, 1'b0, {31{1'b1}}}))
            nw3_next = {1'b0, {31{1'b1}}};
        else if (wsum < $signed({{22{1'b1}}, 31'b0}))
            nw3_next = {1'b1, 31'b0};
        else
            nw3_next = wsum[31:0];
    end

    logic                    fop3_reg;
    logic signed [31:0]      w3_reg;
    logic [WATER_W-1:0]      nw3_reg;
    logic [FLUX_W-1:0]       f3_reg [4];

    always_ff @(posedge clk)
    begin
        fop3_reg <= (op_t'(op2_reg) == OP_FLUX);
        w3_reg   <= w2_reg;
        nw3_reg  <= nw3_next;
        f3_reg   <= f3_next;
    end

    // Stage 4: flux total and the scaling condition.
    logic [TOT_W-1:0]        total;
    logic                    cond4_next;

    always_comb
    begin
        total = '0;
        for (int i = 0; i < 4; i++)
            total = total + {2'b0, f3_reg[i]};
        cond4_next = fop3_reg && (total > {17'b0, floor_reg})
                     && ($signed({1'b0, total}) > $signed({{2{w3_reg[31]}}, w3_reg}));
    end

    logic                    cond4_reg;
    logic [TOT_W-1:0]        total4_reg;
    logic signed [31:0]      w4_reg;
    logic [WATER_W-1:0]      nw4_reg;
    logic [FLUX_W-1:0]       f4_reg [4];

    always_ff @(posedge clk)
    begin
        cond4_reg  <= cond4_next;
        total4_reg <= total;
        w4_reg     <= w3_reg;
        nw4_reg    <= nw3_reg;
        f4_reg     <= f3_reg;
    end

    // Stage 5: total times the time step, and the water magnitude.
    logic                      cond5_reg;
    logic [TOT_W+TS_W-1:0]     pfull5_reg;
    logic [WATER_W-1:0]        aw5_reg;
    logic [WATER_W-1:0]        nw5_reg;
    logic [FLUX_W-1:0]         f5_reg [4];

    always_ff @(posedge clk)
    begin
        cond5_reg  <= cond4_reg;
        pfull5_reg <= total4_reg * ts_reg;
        aw5_reg    <= w4_reg[31] ? (~w4_reg + 32'd1) : w4_reg;
        nw5_reg    <= nw4_reg;
        f5_reg     <= f4_reg;
    end

    // Stage 6: scale decision and the divider's first operands.
    div_t                    dv0_next;
    logic [DW-1:0]           p6;

    always_comb
    begin
        p6 = DW'(pfull5_reg[TOT_W+TS_W-1:FRAC_BITS]);
        dv0_next.nw    = nw5_reg;
        for (int i = 0; i < 4; i++)
            dv0_next.f[i] = f5_reg[i];
        dv0_next.p     = p6;
        dv0_next.rem   = DW'(aw5_reg);
        dv0_next.q     = '0;
        dv0_next.scale = cond5_reg && (p6 != '0) && (DW'(aw5_reg) < p6);
    end

    // Divider stages: one quotient bit of |water| / p per stage.
    div_t                    dv_reg [FRAC_BITS+1];
    div_t                    dv_next [FRAC_BITS];
    logic [DW:0]             r2 [FRAC_BITS];
    logic                    ge [FRAC_BITS];
    logic [DW:0]             r2sub [FRAC_BITS];

    always_comb
    begin
        for (int k = 0; k < FRAC_BITS; k++)
        begin
            r2[k]      = {dv_reg[k].rem, 1'b0};
            ge[k]      = r2[k] >= {1'b0, dv_reg[k].p};
            r2sub[k]   = r2[k] - {1'b0, dv_reg[k].p};
            dv_next[k] = dv_reg[k];
            dv_next[k].rem = ge[k] ? r2sub[k][DW-1:0] : r2[k][DW-1:0];
            dv_next[k].q   = {dv_reg[k].q[FRAC_BITS-2:0], ge[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        dv_reg[0] <= dv0_next;
        for (int k = 0; k < FRAC_BITS; k++)
            dv_reg[k+1] <= dv_next[k];
    end

    // Output stage: apply the scale factor to each flux.
    logic [FLUX_W+FRAC_BITS-1:0] sprod [4];
    logic [FLUX_W-1:0]           fo_reg [4];
    logic [WATER_W-1:0]          nwo_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            sprod[i] = dv_reg[FRAC_BITS].f[i] * dv_reg[FRAC_BITS].q;
    end

    always_ff @(posedge clk)
    begin
        nwo_reg <= dv_reg[FRAC_BITS].nw;
        for (int i = 0; i < 4; i++)
        begin
            if (dv_reg[FRAC_BITS].scale)
                fo_reg[i] <= sprod[i][FLUX_W+FRAC_BITS-1:FRAC_BITS];
            else
                fo_reg[i] <= dv_reg[FRAC_BITS].f[i];
        end
    end

    assign done           = vo_reg;
    assign new_water      = nwo_reg;
    assign new_flux_east  = fo_reg[0];
    assign new_flux_north = fo_reg[1];
    assign new_flux_west  = fo_reg[2];
    assign new_flux_south = fo_reg[3];

endmodule

[hw/rtl/mwc_checker.sv]
// Port-level checker for the water cell step pipeline, bound to the top level.
module mwc_checker
    import mwc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  op,
    input logic [31:0] own_water,
    input logic        cfg_ready,
    input logic        done,
    input logic [31:0] new_water
);

    // Every accepted transaction produces a result strobe, delayed by LATENCY.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted transaction produced no result");

    // No result appears without a transaction accepted at the right time.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without an accepted transaction");

    // A flux update passes the water depth through unchanged.
    a_flux_keeps_water: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op == OP_FLUX) |-> ##LATENCY
        (new_water == $past(own_water, LATENCY)))
        else $error("flux update changed the water depth");

    // The block never refuses commands or configuration.
    a_always_open: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && cfg_ready)
        else $error("block refused a transaction");

endmodule

bind pipe_model_water_cell_step mwc_checker u_mwc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .op        (op),
    .own_water (own_water),
    .cfg_ready (cfg_ready),
    .done      (done),
    .new_water (new_water)
);
